@@ rtl/core/b2ba_pkg.sv @@
// shared types, constants and table functions for the bearing to binary angle block
`timescale 1ns / 1ps

package b2ba_pkg;

    // angle format is unsigned q2.62
    localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C234;
    localparam logic [63:0] Q_ONE     = 64'h4000000000000000;
    localparam int          NUM_TERMS = 20;

    // one cell per angle step k = 1..31 inside an octant
    localparam int          NUM_CELLS = 31;

    localparam logic [5:0]  OCT_FULL  = 6'd32;
    localparam logic [5:0]  OCT_LAST  = 6'd31;
    localparam logic [7:0]  QUARTER   = 8'd64;
    localparam logic [7:0]  HALF_TURN = 8'd128;

    // how the octant step count maps onto the half turn
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_N_LO,
        SEL_N_HI,
        SEL_S_LO,
        SEL_S_HI
    } t_sel;

    typedef struct packed {
        logic       done;
        logic [5:0] steps;
        t_sel       sel;
        logic       adj;
        logic       neg;
        logic [7:0] heading;
    } t_ctl;

    function automatic logic [63:0] mul_q62(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[125:62];
    endfunction

    // taylor series sin or cos of k*pi/128, truncated at every step
    function automatic logic [63:0] trig_q62(input int k, input logic want_sin);
        logic [63:0] step;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] st;
        logic [63:0] ss;
        logic [63:0] ct;
        logic [63:0] cs;
        int          n;
        step = PI_Q62 >> 7;
        x    = 64'(k) * step;
        x2   = mul_q62(x, x);
        st   = x;
        ss   = x;
        ct   = Q_ONE;
        cs   = Q_ONE;
        for (n = 1; n <= NUM_TERMS; n++) begin
            st = mul_q62(st, x2) / 64'((2 * n) * (2 * n + 1));
            ct = mul_q62(ct, x2) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                ss = ss - st;
                cs = cs - ct;
            end else begin
                ss = ss + st;
                cs = cs + ct;
            end
        end
        return want_sin ? ss : cs;
    endfunction

endpackage

@@ rtl/core/b2ba_fold.sv @@
// front stage: difference vector folded into the first octant
`timescale 1ns / 1ps

module b2ba_fold #(
    parameter int COORD_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [COORD_BITS-1:0] i_target_x,
    input  logic [COORD_BITS-1:0] i_target_y,
    input  logic [COORD_BITS-1:0] i_own_x,
    input  logic [COORD_BITS-1:0] i_own_y,
    input  logic [7:0]            i_own_heading,
    output logic                  o_vld,
    output logic [COORD_BITS-1:0] o_a,
    output logic [COORD_BITS-1:0] o_b,
    output b2ba_pkg::t_ctl        o_ctl
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   ny;
    logic [COORD_BITS:0]   dx_neg_val;
    logic [COORD_BITS:0]   ny_neg_val;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] m;
    logic                  lo;

    logic                  r_vld;
    logic [COORD_BITS-1:0] r_a;
    logic [COORD_BITS-1:0] r_b;
    b2ba_pkg::t_ctl        r_ctl;
    logic [COORD_BITS-1:0] n_a;
    logic [COORD_BITS-1:0] n_b;
    b2ba_pkg::t_ctl        n_ctl;

    always_comb begin
        dx         = {1'b0, i_target_x} - {1'b0, i_own_x};
        ny         = {1'b0, i_own_y} - {1'b0, i_target_y};
        dx_neg_val = -dx;
        ny_neg_val = -ny;
        ax         = dx[COORD_BITS] ? dx_neg_val[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        m          = ny[COORD_BITS] ? ny_neg_val[COORD_BITS-1:0] : ny[COORD_BITS-1:0];
        lo         = (ax <= m);

        n_a = lo ? ax : m;
        n_b = lo ? m : ax;

        n_ctl.heading = i_own_heading;
        n_ctl.neg     = dx[COORD_BITS];
        n_ctl.done    = (n_a == n_b);
        n_ctl.steps   = (n_a == n_b) ? b2ba_pkg::OCT_FULL : b2ba_pkg::OCT_LAST;
        n_ctl.adj     = 1'b0;
        if (ax == '0 && m == '0) begin
            n_ctl.sel = b2ba_pkg::SEL_ZERO;
        end else if (!ny[COORD_BITS]) begin
            n_ctl.sel = lo ? b2ba_pkg::SEL_N_LO : b2ba_pkg::SEL_N_HI;
            n_ctl.adj = !lo && (m != '0);
        end else begin
            n_ctl.sel = lo ? b2ba_pkg::SEL_S_LO : b2ba_pkg::SEL_S_HI;
            n_ctl.adj = lo && !(ax == '0 || ax == m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_ctl <= n_ctl;
        end
    end

    assign o_vld = r_vld;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_ctl = r_ctl;

endmodule

@@ rtl/core/b2ba_cell.sv @@
// one angle step cell: compares a*cos(k) against b*sin(k) over three stages
`timescale 1ns / 1ps

module b2ba_cell #(
    parameter int COORD_BITS = 20,
    parameter int K          = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [COORD_BITS-1:0] i_a,
    input  logic [COORD_BITS-1:0] i_b,
    input  b2ba_pkg::t_ctl        i_ctl,
    output logic                  o_vld,
    output logic [COORD_BITS-1:0] o_a,
    output logic [COORD_BITS-1:0] o_b,
    output b2ba_pkg::t_ctl        o_ctl
);

    localparam logic [63:0] COS_K = b2ba_pkg::trig_q62(K, 1'b0);
    localparam logic [63:0] SIN_K = b2ba_pkg::trig_q62(K, 1'b1);
    localparam int          PW    = COORD_BITS + 32;
    localparam int          SW    = COORD_BITS + 64;

    // stage 1: 32-bit partial products
    logic                  r1_vld;
    logic [COORD_BITS-1:0] r1_a;
    logic [COORD_BITS-1:0] r1_b;
    b2ba_pkg::t_ctl        r1_ctl;
    logic [PW-1:0]         r1_ac_lo;
    logic [PW-1:0]         r1_ac_hi;
    logic [PW-1:0]         r1_bs_lo;
    logic [PW-1:0]         r1_bs_hi;

    // stage 2: full products
    logic                  r2_vld;
    logic [COORD_BITS-1:0] r2_a;
    logic [COORD_BITS-1:0] r2_b;
    b2ba_pkg::t_ctl        r2_ctl;
    logic [SW-1:0]         r2_ac;
    logic [SW-1:0]         r2_bs;

    // stage 3: compare and mark the first crossing
    logic                  r3_vld;
    logic [COORD_BITS-1:0] r3_a;
    logic [COORD_BITS-1:0] r3_b;
    b2ba_pkg::t_ctl        r3_ctl;

    logic [PW-1:0]         n1_ac_lo;
    logic [PW-1:0]         n1_ac_hi;
    logic [PW-1:0]         n1_bs_lo;
    logic [PW-1:0]         n1_bs_hi;
    logic [SW-1:0]         n2_ac;
    logic [SW-1:0]         n2_bs;
    b2ba_pkg::t_ctl        n3_ctl;

    always_comb begin
        n1_ac_lo = PW'(i_a) * PW'(COS_K[31:0]);
        n1_ac_hi = PW'(i_a) * PW'(COS_K[63:32]);
        n1_bs_lo = PW'(i_b) * PW'(SIN_K[31:0]);
        n1_bs_hi = PW'(i_b) * PW'(SIN_K[63:32]);
        n2_ac    = (SW'(r1_ac_hi) << 32) + SW'(r1_ac_lo);
        n2_bs    = (SW'(r1_bs_hi) << 32) + SW'(r1_bs_lo);
        n3_ctl   = r2_ctl;
        if (!r2_ctl.done && r2_ac < r2_bs) begin
            n3_ctl.done  = 1'b1;
            n3_ctl.steps = 6'(K - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a     <= i_a;
            r1_b     <= i_b;
            r1_ctl   <= i_ctl;
            r1_ac_lo <= n1_ac_lo;
            r1_ac_hi <= n1_ac_hi;
            r1_bs_lo <= n1_bs_lo;
            r1_bs_hi <= n1_bs_hi;
            r2_a     <= r1_a;
            r2_b     <= r1_b;
            r2_ctl   <= r1_ctl;
            r2_ac    <= n2_ac;
            r2_bs    <= n2_bs;
            r3_a     <= r2_a;
            r3_b     <= r2_b;
            r3_ctl   <= n3_ctl;
        end
    end

    assign o_vld = r3_vld;
    assign o_a   = r3_a;
    assign o_b   = r3_b;
    assign o_ctl = r3_ctl;

endmodule

@@ rtl/core/b2ba_finish.sv @@
// back stage: octant steps to course and turn distance
`timescale 1ns / 1ps

module b2ba_finish (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  b2ba_pkg::t_ctl i_ctl,
    output logic           o_vld,
    output logic [7:0]     o_course,
    output logic [7:0]     o_turn_distance
);

    logic [7:0] steps;
    logic [7:0] adj;
    logic [7:0] half;
    logic [7:0] d;
    logic [7:0] n_course;
    logic [7:0] n_dist;

    logic       r_vld;
    logic [7:0] r_course;
    logic [7:0] r_dist;

    always_comb begin
        steps = {2'b00, i_ctl.steps};
        adj   = {7'd0, i_ctl.adj};
        case (i_ctl.sel)
            b2ba_pkg::SEL_ZERO: half = 8'd0;
            b2ba_pkg::SEL_N_LO: half = steps;
            b2ba_pkg::SEL_N_HI: half = b2ba_pkg::QUARTER - steps - adj;
            b2ba_pkg::SEL_S_LO: half = b2ba_pkg::HALF_TURN - steps - adj;
            b2ba_pkg::SEL_S_HI: half = b2ba_pkg::QUARTER + steps;
            default:            half = 8'd0;
        endcase
        // west half mirrors, wrapped to 8 bits
        n_course = i_ctl.neg ? (~half + 8'd1) : half;
        d        = n_course - i_ctl.heading;
        n_dist   = (d > b2ba_pkg::HALF_TURN) ? (~d + 8'd1) : d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_course <= n_course;
            r_dist   <= n_dist;
        end
    end

    assign o_vld           = r_vld;
    assign o_course        = r_course;
    assign o_turn_distance = r_dist;

endmodule

@@ rtl/core/bearing_to_binary_angle.sv @@
// top level: course to a target as a binary angle, plus turn distance from heading
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_ready   i_target_x, i_target_y, i_own_x,
//                                                  i_own_y, i_own_heading
//   output    out        o_out_valid / i_out_ready o_course, o_turn_distance
//
// one beat is taken every cycle while the skid register is empty
// a beat passes the fold stage, 31 cells of three stages, finish stage and output register
// the cell chain sets the latency: coordinate by 32-bit partial products, a wide add,
// then a compare per angle step
// reset clears the valid bits of every stage, the output register and the skid register
// a stalled output beat parks in the skid register; the chain freezes only while it is full
`timescale 1ns / 1ps

module bearing_to_binary_angle #(
    parameter int COORD_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_target_x,
    input  logic [COORD_BITS-1:0] i_target_y,
    input  logic [COORD_BITS-1:0] i_own_x,
    input  logic [COORD_BITS-1:0] i_own_y,
    input  logic [7:0]            i_own_heading,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_course,
    output logic [7:0]            o_turn_distance
);

    localparam int NC = b2ba_pkg::NUM_CELLS;

    // chain advances whenever the skid register is free
    logic                  en;
    logic                  in_beat;

    // links between fold stage, cells and finish stage
    logic                  w_vld [0:NC];
    logic [COORD_BITS-1:0] w_a   [0:NC];
    logic [COORD_BITS-1:0] w_b   [0:NC];
    b2ba_pkg::t_ctl        w_ctl [0:NC];

    logic                  fin_vld;
    logic [7:0]            fin_course;
    logic [7:0]            fin_dist;

    // output register and skid register
    logic                  push;
    logic                  out_free;
    logic                  r_out_vld;
    logic [7:0]            r_out_course;
    logic [7:0]            r_out_dist;
    logic                  r_skid_vld;
    logic [7:0]            r_skid_course;
    logic [7:0]            r_skid_dist;
    logic                  n_out_vld;
    logic [7:0]            n_out_course;
    logic [7:0]            n_out_dist;
    logic                  n_skid_vld;
    logic [7:0]            n_skid_course;
    logic [7:0]            n_skid_dist;

    assign en         = !r_skid_vld;
    assign o_in_ready = en;
    assign in_beat    = i_in_valid && en;

    // fold into the first octant, remember how to unfold
    b2ba_fold #(
        .COORD_BITS (COORD_BITS)
    ) u_fold (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_vld         (in_beat),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_own_x       (i_own_x),
        .i_own_y       (i_own_y),
        .i_own_heading (i_own_heading),
        .o_vld         (w_vld[0]),
        .o_a           (w_a[0]),
        .o_b           (w_b[0]),
        .o_ctl         (w_ctl[0])
    );

    // one cell per step k; the first cell where a*cos(k) < b*sin(k) fixes the step count
    for (genvar g = 1; g <= NC; g++) begin : g_cell
        b2ba_cell #(
            .COORD_BITS (COORD_BITS),
            .K          (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (w_vld[g-1]),
            .i_a     (w_a[g-1]),
            .i_b     (w_b[g-1]),
            .i_ctl   (w_ctl[g-1]),
            .o_vld   (w_vld[g]),
            .o_a     (w_a[g]),
            .o_b     (w_b[g]),
            .o_ctl   (w_ctl[g])
        );
    end

    // unfold to the full turn and measure against heading
    b2ba_finish u_finish (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_vld           (w_vld[NC]),
        .i_ctl           (w_ctl[NC]),
        .o_vld           (fin_vld),
        .o_course        (fin_course),
        .o_turn_distance (fin_dist)
    );

    // a finished beat leaves the chain on every enabled edge
    assign push     = en && fin_vld;
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_out_vld     = r_out_vld;
        n_out_course  = r_out_course;
        n_out_dist    = r_out_dist;
        n_skid_vld    = r_skid_vld;
        n_skid_course = r_skid_course;
        n_skid_dist   = r_skid_dist;
        if (out_free) begin
            if (r_skid_vld) begin
                // skid drains first to keep order
                n_out_vld    = 1'b1;
                n_out_course = r_skid_course;
                n_out_dist   = r_skid_dist;
                n_skid_vld   = 1'b0;
            end else begin
                n_out_vld    = push;
                n_out_course = fin_course;
                n_out_dist   = fin_dist;
            end
        end else if (push) begin
            // output held, park the new beat
            n_skid_vld    = 1'b1;
            n_skid_course = fin_course;
            n_skid_dist   = fin_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_course  <= n_out_course;
        r_out_dist    <= n_out_dist;
        r_skid_course <= n_skid_course;
        r_skid_dist   <= n_skid_dist;
    end

    assign o_out_valid     = r_out_vld;
    assign o_course        = r_out_course;
    assign o_turn_distance = r_out_dist;

`ifndef SYNTHESIS
    // skid only ever holds a beat behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while output register empty");

    // a drained skid beat lands in the output register
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_out_ready) |=> (o_out_valid && !r_skid_vld))
        else $error("skid beat lost on drain");

    // an accepted input beat enters the fold stage
    a_in_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_vld[0])
        else $error("accepted input beat missing from fold stage");

    // turn distance never exceeds half a turn
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_turn_distance <= b2ba_pkg::HALF_TURN))
        else $error("turn distance above half turn");
`endif

endmodule
